>>> src/dlt_pkg.sv
`timescale 1ns / 1ps
// Package for the DHCP lease table: sizes, register reset values, codes and shared types.
// Used by dlt_seq and dhcp_lease_table_unit in src; has no dependencies of its own.
package dlt_pkg;

    // Table geometry.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths.
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int LEASE_W = 24;
    localparam int CD_W    = 25;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 2;
    localparam int SLOTO_W = 3;
    localparam int CFG_W   = 32;

    // Configuration register reset values and fixed lease margin.
    localparam logic [IP_W-1:0]    SERVER_ADDRESS_RST = 32'hC0A8_5101;
    localparam logic [LEASE_W-1:0] LEASE_SECONDS_RST  = 24'd1800;
    localparam logic [CD_W-1:0]    LEASE_MARGIN       = 25'd300;

    localparam logic [MAC_W-1:0] MAC_ALL_ONES = '1;

    // Configuration register indexes.
    localparam logic CFG_SERVER_ADDRESS = 1'b0;
    localparam logic CFG_LEASE_SECONDS  = 1'b1;

    // Input actions.
    localparam logic [ACT_W-1:0] ACT_DISCOVER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REQUEST  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        REPLY_NONE  = 2'd0,
        REPLY_OFFER = 2'd1,
        REPLY_ACK   = 2'd2,
        REPLY_NAK   = 2'd3
    } reply_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CMP,
        ST_DECIDE,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_REPLY
    } seq_state_t;

    // One entry of the lookup memory.
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  addr;
    } lk_entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        lk_entry_t         wdata;
    } lk_req_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [CD_W-1:0]   wdata;
    } cd_req_t;

    typedef struct packed {
        reply_kind_t        kind;
        logic [IP_W-1:0]    addr;
        logic [SLOTO_W-1:0] slot;
    } result_t;

endpackage

>>> src/dlt_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read, read-before-write.
// No dependencies.
module dlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dlt_seq.sv
`timescale 1ns / 1ps
// Sequencer of the lease table: walks the slots through the two memories, keeps the
// valid and written bits, and forms one result per item. Depends on dlt_pkg.
module dlt_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dlt_pkg::ACT_W-1:0]    action,
    input  logic [dlt_pkg::MAC_W-1:0]    client_mac,
    input  logic [dlt_pkg::IP_W-1:0]     requested_address,
    input  logic                         sid_present,
    input  logic [dlt_pkg::IP_W-1:0]     sid_address,
    input  logic [dlt_pkg::IP_W-1:0]     server_address,
    input  logic [dlt_pkg::LEASE_W-1:0]  lease_seconds,
    output dlt_pkg::lk_req_t             lk_req,
    input  dlt_pkg::lk_entry_t           lk_rdata,
    output dlt_pkg::cd_req_t             cd_req,
    input  logic [dlt_pkg::CD_W-1:0]     cd_rdata,
    output logic                         res_valid,
    output dlt_pkg::result_t             res,
    input  logic                         res_take
);

    dlt_pkg::seq_state_t              state_reg, state_next;
    logic [dlt_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    logic [dlt_pkg::ACT_W-1:0]        act_reg, act_next;
    logic [dlt_pkg::MAC_W-1:0]        mac_reg, mac_next;
    logic [dlt_pkg::IP_W-1:0]         req_reg, req_next;
    logic                             found_reg, found_next;
    logic [dlt_pkg::SLOT_W-1:0]       found_slot_reg, found_slot_next;
    logic [dlt_pkg::IP_W-1:0]         found_addr_reg, found_addr_next;
    logic                             free_found_reg, free_found_next;
    logic [dlt_pkg::SLOT_W-1:0]       free_slot_reg, free_slot_next;
    logic [dlt_pkg::SLOTS-1:0]        valid_reg, valid_next;
    logic [dlt_pkg::SLOTS-1:0]        written_reg, written_next;
    dlt_pkg::result_t                 res_reg, res_next;

    dlt_pkg::lk_entry_t               lk_entry;
    logic                             last_slot;
    logic                             pick_ok;
    logic [dlt_pkg::SLOT_W-1:0]       pick_slot;
    logic [dlt_pkg::IP_W-1:0]         pick_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dlt_pkg::ST_IDLE;
            valid_reg   <= '0;
            written_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            written_reg <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        act_reg        <= act_next;
        mac_reg        <= mac_next;
        req_reg        <= req_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        found_addr_reg <= found_addr_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        res_reg        <= res_next;
    end

    // A slot never written reads as all zero.
    assign lk_entry  = written_reg[idx_reg] ? lk_rdata : '0;
    assign last_slot = (idx_reg == dlt_pkg::SLOT_W'(dlt_pkg::SLOTS - 1));

    assign pick_ok   = found_reg || free_found_reg;
    assign pick_slot = found_reg ? found_slot_reg : free_slot_reg;
    assign pick_addr = found_reg ? found_addr_reg
                     : server_address + dlt_pkg::IP_W'(free_slot_reg) + dlt_pkg::IP_W'(1);

    assign in_ready  = (state_reg == dlt_pkg::ST_IDLE);
    assign res_valid = (state_reg == dlt_pkg::ST_REPLY);
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        act_next        = act_reg;
        mac_next        = mac_reg;
        req_next        = req_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        found_addr_next = found_addr_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        valid_next      = valid_reg;
        written_next    = written_reg;
        res_next        = res_reg;

        lk_req.we       = 1'b0;
        lk_req.addr     = idx_reg;
        lk_req.wdata    = lk_entry;
        cd_req.we       = 1'b0;
        cd_req.addr     = idx_reg;
        cd_req.wdata    = cd_rdata;

        case (state_reg)
            dlt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = action;
                    mac_next        = client_mac;
                    req_next        = requested_address;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    res_next        = '0;
                    if (action == dlt_pkg::ACT_DISCOVER)
                    begin
                        if (client_mac == '0 || client_mac == dlt_pkg::MAC_ALL_ONES)
                        begin
                            state_next = dlt_pkg::ST_REPLY;
                        end
                        else
                        begin
                            state_next = dlt_pkg::ST_LOOK_RD;
                        end
                    end
                    else if (action == dlt_pkg::ACT_REQUEST)
                    begin
                        if (sid_present && sid_address != server_address)
                        begin
                            state_next = dlt_pkg::ST_REPLY;
                        end
                        else
                        begin
                            state_next = dlt_pkg::ST_LOOK_RD;
                        end
                    end
                    else if (action == dlt_pkg::ACT_TICK)
                    begin
                        state_next = dlt_pkg::ST_TICK_RD;
                    end
                    else
                    begin
                        state_next = dlt_pkg::ST_REPLY;
                    end
                end
            end

            dlt_pkg::ST_LOOK_RD:
            begin
                state_next = dlt_pkg::ST_LOOK_CMP;
            end

            dlt_pkg::ST_LOOK_CMP:
            begin
                // The first slot with a clear valid bit is noted on the way past.
                if (!valid_reg[idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = idx_reg;
                end
                if (lk_entry.mac == mac_reg)
                begin
                    found_next      = 1'b1;
                    found_slot_next = idx_reg;
                    found_addr_next = lk_entry.addr;
                    state_next      = dlt_pkg::ST_DECIDE;
                end
                else if (last_slot)
                begin
                    state_next = dlt_pkg::ST_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + dlt_pkg::SLOT_W'(1);
                    state_next = dlt_pkg::ST_LOOK_RD;
                end
            end

            dlt_pkg::ST_DECIDE:
            begin
                state_next   = dlt_pkg::ST_REPLY;
                lk_req.addr  = pick_slot;
                cd_req.addr  = pick_slot;
                lk_req.wdata = '{mac: mac_reg, addr: pick_addr};
                cd_req.wdata = dlt_pkg::CD_W'(lease_seconds) + dlt_pkg::LEASE_MARGIN;
                if (pick_ok)
                begin
                    res_next.addr = pick_addr;
                    res_next.slot = dlt_pkg::SLOTO_W'(pick_slot);
                    if (act_reg == dlt_pkg::ACT_DISCOVER)
                    begin
                        res_next.kind = dlt_pkg::REPLY_OFFER;
                    end
                    else if (req_reg != pick_addr)
                    begin
                        res_next.kind = dlt_pkg::REPLY_NAK;
                    end
                    else
                    begin
                        res_next.kind           = dlt_pkg::REPLY_ACK;
                        lk_req.we               = 1'b1;
                        cd_req.we               = 1'b1;
                        valid_next[pick_slot]   = 1'b1;
                        written_next[pick_slot] = 1'b1;
                    end
                end
            end

            dlt_pkg::ST_TICK_RD:
            begin
                state_next = dlt_pkg::ST_TICK_CMP;
            end

            dlt_pkg::ST_TICK_CMP:
            begin
                if (valid_reg[idx_reg])
                begin
                    cd_req.we = 1'b1;
                    if (cd_rdata <= dlt_pkg::CD_W'(1))
                    begin
                        cd_req.wdata        = '0;
                        valid_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        cd_req.wdata = cd_rdata - dlt_pkg::CD_W'(1);
                    end
                end
                if (last_slot)
                begin
                    state_next = dlt_pkg::ST_REPLY;
                end
                else
                begin
                    idx_next   = idx_reg + dlt_pkg::SLOT_W'(1);
                    state_next = dlt_pkg::ST_TICK_RD;
                end
            end

            dlt_pkg::ST_REPLY:
            begin
                if (res_take)
                begin
                    state_next = dlt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dlt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/dhcp_lease_table_unit.sv
`timescale 1ns / 1ps
// Top level of the DHCP server lease table: configuration registers, output register,
// the slot sequencer and the two table memories. Depends on dlt_pkg, dlt_seq, dlt_ram.
//
//  Channel  | Signals                                              | Moves
//  ---------+------------------------------------------------------+----------------------
//  input    | in_valid/in_ready, action, client_mac,               | one item per transfer
//           | requested_address, sid_present, sid_address          |
//  output   | out_valid/out_ready, reply_kind, client_address,     | one result per item
//           | slot_index                                           |
//  config   | cfg_we, cfg_index, cfg_data                          | one register per write
//
// A discover or request scans the slots in turn (memory read, then compare), stopping at
// the first MAC match, then passes through a decide and a reply state. A tick walks every
// slot through the countdown memory; dropped items go straight to the reply state. A new
// item is taken only once the sequencer is back in its idle state.
// Reset clears the valid and written bits at once, so no clearing pass is needed. A stalled
// output holds the sequencer in its reply state until the output register has room.
module dhcp_lease_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dlt_pkg::ACT_W-1:0]     action,
    input  logic [dlt_pkg::MAC_W-1:0]     client_mac,
    input  logic [dlt_pkg::IP_W-1:0]      requested_address,
    input  logic                          sid_present,
    input  logic [dlt_pkg::IP_W-1:0]      sid_address,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dlt_pkg::KIND_W-1:0]    reply_kind,
    output logic [dlt_pkg::IP_W-1:0]      client_address,
    output logic [dlt_pkg::SLOTO_W-1:0]   slot_index,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [dlt_pkg::CFG_W-1:0]     cfg_data
);

    logic [dlt_pkg::IP_W-1:0]    server_address_reg;
    logic [dlt_pkg::LEASE_W-1:0] lease_seconds_reg;

    logic                        out_valid_reg, out_valid_next;
    dlt_pkg::result_t            out_res_reg;

    dlt_pkg::lk_req_t            lk_req;
    dlt_pkg::lk_entry_t          lk_rdata;
    dlt_pkg::cd_req_t            cd_req;
    logic [dlt_pkg::CD_W-1:0]    cd_rdata;
    logic                        res_valid;
    dlt_pkg::result_t            res;
    logic                        res_take;

    // Configuration writes are to be made only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_address_reg <= dlt_pkg::SERVER_ADDRESS_RST;
            lease_seconds_reg  <= dlt_pkg::LEASE_SECONDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dlt_pkg::CFG_SERVER_ADDRESS:
                begin
                    server_address_reg <= cfg_data[dlt_pkg::IP_W-1:0];
                end
                dlt_pkg::CFG_LEASE_SECONDS:
                begin
                    lease_seconds_reg <= cfg_data[dlt_pkg::LEASE_W-1:0];
                end
                default:
                begin
                    server_address_reg <= server_address_reg;
                end
            endcase
        end
    end

    // The result moves into the output register whenever that register is empty or is
    // being emptied in the same cycle.
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reply_kind     = out_res_reg.kind;
    assign client_address = out_res_reg.addr;
    assign slot_index     = out_res_reg.slot;

    dlt_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .client_mac        (client_mac),
        .requested_address (requested_address),
        .sid_present       (sid_present),
        .sid_address       (sid_address),
        .server_address    (server_address_reg),
        .lease_seconds     (lease_seconds_reg),
        .lk_req            (lk_req),
        .lk_rdata          (lk_rdata),
        .cd_req            (cd_req),
        .cd_rdata          (cd_rdata),
        .res_valid         (res_valid),
        .res               (res),
        .res_take          (res_take)
    );

    // MAC and address of each slot.
    dlt_ram #(
        .WIDTH ($bits(dlt_pkg::lk_entry_t)),
        .DEPTH (dlt_pkg::SLOTS)
    ) u_lookup_ram (
        .clk   (clk),
        .we    (lk_req.we),
        .addr  (lk_req.addr),
        .wdata (lk_req.wdata),
        .rdata (lk_rdata)
    );

    // Remaining lease ticks of each slot.
    dlt_ram #(
        .WIDTH (dlt_pkg::CD_W),
        .DEPTH (dlt_pkg::SLOTS)
    ) u_countdown_ram (
        .clk   (clk),
        .we    (cd_req.we),
        .addr  (cd_req.addr),
        .wdata (cd_req.wdata),
        .rdata (cd_rdata)
    );

endmodule

>>> test/dlt_lease_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the DHCP lease table: watches the item, result and register ports, keeps
// its own copy of the lease table and compares each result. Depends on dlt_pkg.
module dlt_lease_checker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [dlt_pkg::ACT_W-1:0]     action,
    input  logic [dlt_pkg::MAC_W-1:0]     client_mac,
    input  logic [dlt_pkg::IP_W-1:0]      requested_address,
    input  logic                          sid_present,
    input  logic [dlt_pkg::IP_W-1:0]      sid_address,

    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [dlt_pkg::KIND_W-1:0]    reply_kind,
    input  logic [dlt_pkg::IP_W-1:0]      client_address,
    input  logic [dlt_pkg::SLOTO_W-1:0]   slot_index,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [dlt_pkg::CFG_W-1:0]     cfg_data,

    output int                            mismatches,
    output int                            pending
);
    import dlt_pkg::*;

    // Shadow copy of the lease table and of the two registers.
    logic               lease_valid [SLOTS];
    logic [MAC_W-1:0]   lease_mac   [SLOTS];
    logic [IP_W-1:0]    lease_addr  [SLOTS];
    logic [CD_W-1:0]    lease_left  [SLOTS];
    logic [IP_W-1:0]    pool_base;
    logic [LEASE_W-1:0] grant_time;

    result_t            awaited_replies [$];
    int                 fault_count = 0;

    assign mismatches = fault_count;

    // The MAC lookup ignores the valid bit; only a miss falls back to the first free slot.
    function automatic bit locate_slot(input logic [MAC_W-1:0] mac, output int slot,
                                       output logic [IP_W-1:0] addr);
        bit found;
        found = 1'b0;
        slot  = 0;
        addr  = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (!found && lease_mac[k] == mac)
            begin
                found = 1'b1;
                slot  = k;
                addr  = lease_addr[k];
            end
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            if (!found && !lease_valid[k])
            begin
                found = 1'b1;
                slot  = k;
                addr  = pool_base + IP_W'(k) + IP_W'(1);
            end
        end
        return found;
    endfunction

    task automatic age_leases();
        for (int k = 0; k < SLOTS; k++)
        begin
            if (lease_valid[k])
            begin
                if (lease_left[k] > CD_W'(1))
                    lease_left[k] = lease_left[k] - CD_W'(1);
                else
                begin
                    lease_left[k]  = '0;
                    lease_valid[k] = 1'b0;
                end
            end
        end
    endtask

    task automatic serve_item(input logic [ACT_W-1:0] act, input logic [MAC_W-1:0] mac,
                              input logic [IP_W-1:0] req, input logic sid_p,
                              input logic [IP_W-1:0] sid, output result_t reply);
        bit              hit;
        int              slot;
        logic [IP_W-1:0] addr;
        reply.kind = REPLY_NONE;
        reply.addr = '0;
        reply.slot = '0;
        hit = locate_slot(mac, slot, addr);
        if (act == ACT_DISCOVER)
        begin
            if (hit && mac != '0 && mac != MAC_ALL_ONES)
            begin
                reply.kind = REPLY_OFFER;
                reply.addr = addr;
                reply.slot = SLOTO_W'(slot);
            end
        end
        else if (act == ACT_REQUEST)
        begin
            if (hit && !(sid_p && sid != pool_base))
            begin
                reply.addr = addr;
                reply.slot = SLOTO_W'(slot);
                if (req != addr)
                    reply.kind = REPLY_NAK;
                else
                begin
                    reply.kind       = REPLY_ACK;
                    lease_valid[slot] = 1'b1;
                    lease_mac[slot]   = mac;
                    lease_addr[slot]  = addr;
                    lease_left[slot]  = CD_W'(grant_time) + LEASE_MARGIN;
                end
            end
        end
        else if (act == ACT_TICK)
            age_leases();
    endtask

    task automatic flag_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                lease_valid[k] = 1'b0;
                lease_mac[k]   = '0;
                lease_addr[k]  = '0;
                lease_left[k]  = '0;
            end
            pool_base  = SERVER_ADDRESS_RST;
            grant_time = LEASE_SECONDS_RST;
            awaited_replies.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SERVER_ADDRESS)
                    pool_base = cfg_data;
                else
                    grant_time = cfg_data[LEASE_W-1:0];
            end

            // A result and a new item can share an edge; the result always belongs to an
            // earlier item, so it is checked first.
            if (out_valid && out_ready)
            begin
                if (awaited_replies.size() == 0)
                    flag_fault($sformatf("unexpected result kind %0d addr %h slot %0d",
                                         reply_kind, client_address, slot_index));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (reply_kind !== want.kind || client_address !== want.addr ||
                        slot_index !== want.slot)
                        flag_fault($sformatf(
                            "expected kind %0d addr %h slot %0d, got kind %0d addr %h slot %0d",
                            want.kind, want.addr, want.slot,
                            reply_kind, client_address, slot_index));
                end
            end

            if (in_valid && in_ready)
            begin
                serve_item(action, client_mac, requested_address, sid_present,
                           sid_address, fresh);
                awaited_replies.push_back(fresh);
            end

            pending <= awaited_replies.size();
        end
    end

endmodule

>>> test/dhcp_lease_table_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the DHCP lease table: clock, reset, stimulus on the item and register
// ports, random back-pressure on the result port and the verdict. Needs dlt_pkg,
// dhcp_lease_table_unit and dlt_lease_checker.
module dhcp_lease_table_unit_test;
    import dlt_pkg::*;

    localparam int POOL     = 12;               // more clients than slots, so the table fills
    localparam int MAX_WAIT = 12;               // longest idle gap on either side
    localparam int SETTLE   = 2 * SLOTS + 8;    // beyond the slowest item's latency
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                 clk               = 1'b0;
    logic                 rst_n             = 1'b0;
    logic                 in_valid          = 1'b0;
    logic                 in_ready;
    logic [ACT_W-1:0]     action            = ACT_DISCOVER;
    logic [MAC_W-1:0]     client_mac        = '0;
    logic [IP_W-1:0]      requested_address = '0;
    logic                 sid_present       = 1'b0;
    logic [IP_W-1:0]      sid_address       = '0;
    logic                 out_valid;
    logic                 out_ready         = 1'b0;
    logic [KIND_W-1:0]    reply_kind;
    logic [IP_W-1:0]      client_address;
    logic [SLOTO_W-1:0]   slot_index;
    logic                 cfg_we            = 1'b0;
    logic                 cfg_index         = CFG_SERVER_ADDRESS;
    logic [CFG_W-1:0]     cfg_data          = '0;

    int                   mismatches;
    int                   pending;

    // Stimulus bookkeeping. pool_server mirrors what was last written to the server
    // register so that well-formed requests can name this server. last_address is the
    // address carried by the most recent result transfer; a request built from it
    // completes the discover/request exchange of a real client.
    logic [MAC_W-1:0]     client_pool [POOL];
    logic [IP_W-1:0]      pool_server  = SERVER_ADDRESS_RST;
    logic [IP_W-1:0]      last_address = '0;
    int                   items_sent   = 0;
    bit                   steady_in    = 1'b0;
    bit                   steady_out   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dhcp_lease_table_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .client_mac        (client_mac),
        .requested_address (requested_address),
        .sid_present       (sid_present),
        .sid_address       (sid_address),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .reply_kind        (reply_kind),
        .client_address    (client_address),
        .slot_index        (slot_index),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    dlt_lease_checker lease_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .client_mac        (client_mac),
        .requested_address (requested_address),
        .sid_present       (sid_present),
        .sid_address       (sid_address),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .reply_kind        (reply_kind),
        .client_address    (client_address),
        .slot_index        (slot_index),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .pending           (pending)
    );

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    // Mostly known clients, now and then one of the two blocked hardware addresses.
    function automatic logic [MAC_W-1:0] pick_client();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return MAC_ALL_ONES;
        return client_pool[$urandom_range(0, POOL - 1)];
    endfunction

    // One input transfer. Inputs only change at the falling edge. With a zero gap the
    // valid stays high and only the payload moves on to the next item.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [MAC_W-1:0] mac,
                             input logic [IP_W-1:0] req, input logic sid_p,
                             input logic [IP_W-1:0] sid);
        int gap;
        if ($urandom_range(0, 39) == 0)
            steady_in = !steady_in;
        gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action            <= act;
        client_mac        <= mac;
        requested_address <= req;
        sid_present       <= sid_p;
        sid_address       <= sid;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Holds off the sender until every result in flight has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Register writes only happen with the block idle, after a margin for any item that
    // the sequencer may still be finishing.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SERVER_ADDRESS)
            pool_server = data;
    endtask

    // A client's normal exchange: discover, wait for the offer, then request exactly the
    // offered address from this server. Dropped discovers lead to a request for 0.
    task automatic lease_exchange(input logic [MAC_W-1:0] mac, input logic sid_p);
        send_item(ACT_DISCOVER, mac, $urandom, 1'($urandom_range(0, 1)), $urandom);
        wait_drained();
        send_item(ACT_REQUEST, mac, last_address, sid_p, pool_server);
    endtask

    task automatic random_item();
        int               pick;
        logic [MAC_W-1:0] mac;
        pick = $urandom_range(0, 99);
        mac  = pick_client();
        if (pick < 40)
            lease_exchange(mac, 1'($urandom_range(0, 1)));
        else if (pick < 55)
            send_item(ACT_TICK, random_mac(), $urandom, 1'($urandom_range(0, 1)), $urandom);
        else if (pick < 65)
            // Random requested address: almost always refused.
            send_item(ACT_REQUEST, mac, $urandom, 1'($urandom_range(0, 1)), pool_server);
        else if (pick < 75)
            // Server identifier of some other server: dropped.
            send_item(ACT_REQUEST, mac, pool_server + IP_W'($urandom_range(1, SLOTS)),
                      1'b1, $urandom);
        else if (pick < 85)
            // Renewal that guesses a pool address; right now and then.
            send_item(ACT_REQUEST, mac, pool_server + IP_W'($urandom_range(1, SLOTS)),
                      1'($urandom_range(0, 1)), pool_server);
        else if (pick < 90)
            send_item(ACT_DISCOVER, mac, $urandom, 1'($urandom_range(0, 1)), $urandom);
        else
            send_item(ACT_W'($urandom_range(0, 3)), random_mac(), $urandom,
                      1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            random_item();
    endtask

    // Result side: before each result it draws a stall, then holds ready high until the
    // transfer happens. Runs of zero stalls come and go at random.
    initial
    begin : result_drain
        int stall;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady_out = !steady_out;
            stall = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            last_address = client_address;
        end
    end

    initial
    begin : stimulus
        logic [MAC_W-1:0] seed_mac;
        logic [IP_W-1:0]  srv;

        // Distinct clients: the low byte is the pool position plus one, so none of them is
        // the all-zero or all-ones address.
        for (int i = 0; i < POOL; i++)
        begin
            seed_mac       = random_mac();
            client_pool[i] = {seed_mac[MAC_W-1:8], 8'(i + 1)};
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short leases from the start (300 ticks), so that a tick burst later can empty the
        // table. The server address keeps its reset value for the directed part.
        write_reg(CFG_LEASE_SECONDS, '0);
        srv = pool_server;

        // Directed part. Blocked addresses first, then a normal exchange in slot 0.
        send_item(ACT_DISCOVER, '0, srv + 1, 1'b0, '0);
        send_item(ACT_DISCOVER, MAC_ALL_ONES, srv + 1, 1'b1, srv);
        send_item(ACT_DISCOVER, client_pool[0], '0, 1'b0, '0);
        send_item(ACT_REQUEST, client_pool[0], srv + 1, 1'b1, srv);
        // Foreign server, then wrong address, then the right one for slot 1.
        send_item(ACT_REQUEST, client_pool[1], srv + 2, 1'b1, ~srv);
        send_item(ACT_REQUEST, client_pool[1], srv + 5, 1'b0, '0);
        send_item(ACT_REQUEST, client_pool[1], srv + 2, 1'b0, ~srv);
        // Known client: the stored address comes back.
        send_item(ACT_DISCOVER, client_pool[0], '0, 1'b0, '0);
        send_item(ACT_TICK, random_mac(), $urandom, 1'b1, $urandom);
        send_item(ACT_UNUSED, client_pool[0], srv + 1, 1'b1, srv);
        // The all-zero address matches a slot never written, whose address is 0.
        send_item(ACT_REQUEST, '0, srv + 3, 1'b0, '0);
        send_item(ACT_REQUEST, '0, '0, 1'b1, srv);
        // Requests are not blocked for the all-ones address.
        send_item(ACT_REQUEST, MAC_ALL_ONES, srv + 4, 1'b0, '0);
        // Fill the remaining slots, then a new client finds the table full.
        for (int i = 2; i < 6; i++)
            send_item(ACT_REQUEST, client_pool[i], srv + IP_W'(i + 3), 1'b1, srv);
        send_item(ACT_DISCOVER, client_pool[6], '0, 1'b0, '0);
        send_item(ACT_REQUEST, client_pool[6], srv + 1, 1'b0, '0);
        send_item(ACT_DISCOVER, client_pool[2], '0, 1'b0, '0);

        // Full table with short leases, then enough ticks to let every lease run out.
        random_phase(120);
        repeat (LEASE_MARGIN + 2)
            send_item(ACT_TICK, random_mac(), $urandom, 1'($urandom_range(0, 1)), $urandom);

        // Pool base at the top of the address space, so offers wrap past zero, and the
        // longest lease the register holds.
        write_reg(CFG_SERVER_ADDRESS, '1);
        write_reg(CFG_LEASE_SECONDS, CFG_W'(MAC_ALL_ONES[LEASE_W-1:0]));
        random_phase(150);

        // Pool base at zero and a random short lease.
        write_reg(CFG_SERVER_ADDRESS, '0);
        write_reg(CFG_LEASE_SECONDS, CFG_W'($urandom_range(1, 100)));
        random_phase(80);

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // A healthy run needs well under a tenth of this.
    initial
    begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/dlt_pkg.sv
src/dlt_ram.sv
src/dlt_seq.sv
src/dhcp_lease_table_unit.sv
test/dlt_lease_checker.sv
test/dhcp_lease_table_unit_test.sv
